### hw/rtl/crq_pkg.sv
// Shared types and codes for the capture request queue.
// No dependencies; imported by capture_request_queue and its testbench.
`default_nettype none

package crq_pkg;

	// Operation codes carried on func.
	localparam logic [1:0] FUNC_SUBMIT     = 2'd0;
	localparam logic [1:0] FUNC_GET_NEXT   = 2'd1;
	localparam logic [1:0] FUNC_STOP_BY_ID = 2'd2;
	localparam logic [1:0] FUNC_STOP_ANY   = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_NO_REPEAT   = 3'd1;
	localparam logic [2:0] ST_ID_MISMATCH = 3'd2;
	localparam logic [2:0] ST_NOTHING     = 3'd3;
	localparam logic [2:0] ST_QUEUE_FULL  = 3'd4;

	// Frame value that marks an invalid or absent frame (minus one).
	localparam logic [63:0] FRAME_INVALID = 64'hFFFF_FFFF_FFFF_FFFF;

	// One queued one-shot burst as held in the queue memory.
	typedef struct packed {
		logic [31:0] id;
		logic [7:0]  length;
	} burst_entry_t;

endpackage

`default_nettype wire

### hw/rtl/capture_request_queue.sv
// Capture request queue: burst scheduler with a queue memory and a repeating slot.
// Depends on crq_pkg for operation codes, status codes and the entry type.
`default_nettype none

// On transfer the command is registered and the head entry of the queue memory
// is read into a register; while busy is high the result is formed and the
// state is updated, and no new command is taken. Exactly one result follows
// each command, marked by a one-cycle done strobe in the cycle after busy
// falls; the receiver cannot stall it and must take it in that cycle. Frame
// numbers are 64-bit and wrap; -1 marks an invalid frame. Request ids are
// assigned in sequence and wrap at 32 bits.
module capture_request_queue
	import crq_pkg::*;
#(
	parameter int QUEUE_DEPTH = 16
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                start,
	output logic               busy,
	input  wire         [1:0]  func,
	input  wire         [7:0]  burst_length,
	input  wire                is_repeating,
	input  wire         [31:0] request_id,
	output logic               done,
	output logic        [2:0]  status,
	output logic        [31:0] result_id,
	output logic signed [63:0] frame_number
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
	localparam int TOT_W = 8 + OCC_W;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
	localparam logic [OCC_W-1:0] OCC_FULL = OCC_W'(QUEUE_DEPTH);

	// Queue memory.
	burst_entry_t mem [QUEUE_DEPTH];

	// Architectural state.
	logic [PTR_W-1:0] head_q, tail_q;
	logic [OCC_W-1:0] occ_q;
	logic [TOT_W-1:0] total_q;
	logic [63:0]      frame_cnt_q;
	logic             rep_valid_q;
	logic [31:0]      rep_id_q;
	logic [7:0]       rep_len_q;
	logic [63:0]      rep_end_q;
	logic [31:0]      next_id_q;

	// Command held while busy.
	logic             valid_s1;
	logic [1:0]       func_s1;
	logic [7:0]       len_s1;
	logic             rep_s1;
	logic [31:0]      req_s1;
	burst_entry_t     head_s1;

	// Result registers.
	logic             done_q;
	logic [2:0]       status_q;
	logic [31:0]      rid_q;
	logic [63:0]      frame_q;

	logic             accept;
	logic [2:0]       status_d;
	logic [31:0]      rid_d;
	logic [63:0]      frame_d;
	logic             push, pop, issue_rep, set_rep, clr_rep;
	logic [TOT_W-1:0] total_push;
	logic [63:0]      rep_last;

	assign busy   = valid_s1;
	assign accept = start && !valid_s1;

	// Capture the command and read the head entry on transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func;
			len_s1  <= burst_length;
			rep_s1  <= is_repeating;
			req_s1  <= request_id;
			head_s1 <= mem[head_q];
		end
	end

	// Write a new one-shot burst at the tail. The write lands before any
	// later command can read, so no forwarding is needed.
	always_ff @(posedge clk) begin
		if (push) begin
			mem[tail_q] <= '{id: next_id_q, length: len_s1};
		end
	end

	assign total_push = total_q + TOT_W'(len_s1);
	assign rep_last   = (rep_end_q == FRAME_INVALID) ? FRAME_INVALID : rep_end_q - 64'd1;

	// Decode the held command into a result and state updates.
	always_comb begin
		status_d  = ST_OK;
		rid_d     = 32'd0;
		frame_d   = FRAME_INVALID;
		push      = 1'b0;
		pop       = 1'b0;
		issue_rep = 1'b0;
		set_rep   = 1'b0;
		clr_rep   = 1'b0;
		if (valid_s1) begin
			case (func_s1)
				FUNC_SUBMIT: begin
					if (rep_s1) begin
						rid_d   = next_id_q;
						set_rep = 1'b1;
						if (rep_valid_q) begin
							frame_d = rep_last;
						end
					end else if (occ_q >= OCC_FULL) begin
						status_d = ST_QUEUE_FULL;
					end else begin
						rid_d   = next_id_q;
						push    = 1'b1;
						frame_d = frame_cnt_q + 64'(total_push) - 64'd1;
					end
				end
				FUNC_GET_NEXT: begin
					if (occ_q != '0) begin
						pop     = 1'b1;
						rid_d   = head_s1.id;
						frame_d = frame_cnt_q;
					end else if (rep_valid_q) begin
						issue_rep = 1'b1;
						rid_d     = rep_id_q;
						frame_d   = frame_cnt_q;
					end else begin
						status_d = ST_NOTHING;
					end
				end
				default: begin
					if (!rep_valid_q) begin
						status_d = ST_NO_REPEAT;
					end else if (func_s1 == FUNC_STOP_BY_ID && rep_id_q != req_s1) begin
						status_d = ST_ID_MISMATCH;
					end else begin
						clr_rep = 1'b1;
						frame_d = rep_last;
					end
				end
			endcase
		end
	end

	// Queue pointers, fill count and running total of queued lengths.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			occ_q   <= '0;
			total_q <= '0;
		end else if (push) begin
			tail_q  <= (tail_q == PTR_LAST) ? '0 : tail_q + PTR_W'(1);
			occ_q   <= occ_q + OCC_W'(1);
			total_q <= total_push;
		end else if (pop) begin
			head_q  <= (head_q == PTR_LAST) ? '0 : head_q + PTR_W'(1);
			occ_q   <= occ_q - OCC_W'(1);
			total_q <= total_q - TOT_W'(head_s1.length);
		end
	end

	// Frame counter, id counter and the repeating slot.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_cnt_q <= '0;
			next_id_q   <= '0;
			rep_valid_q <= 1'b0;
			rep_id_q    <= '0;
			rep_len_q   <= '0;
			rep_end_q   <= FRAME_INVALID;
		end else begin
			if (push || set_rep) begin
				next_id_q <= next_id_q + 32'd1;
			end
			if (pop) begin
				frame_cnt_q <= frame_cnt_q + 64'(head_s1.length);
			end else if (issue_rep) begin
				frame_cnt_q <= frame_cnt_q + 64'(rep_len_q);
				rep_end_q   <= frame_cnt_q + 64'(rep_len_q);
			end
			if (set_rep) begin
				rep_valid_q <= 1'b1;
				rep_id_q    <= next_id_q;
				rep_len_q   <= len_s1;
				rep_end_q   <= FRAME_INVALID;
			end else if (clr_rep) begin
				rep_valid_q <= 1'b0;
				rep_end_q   <= FRAME_INVALID;
			end
		end
	end

	// Result registers: one strobe per command.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			status_q <= status_d;
			rid_q    <= rid_d;
			frame_q  <= frame_d;
		end
	end

	assign done         = done_q;
	assign status       = status_q;
	assign result_id    = rid_q;
	assign frame_number = $signed(frame_q);

	// Checks.
	a_done_follows_work: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(valid_s1))
		else $error("result strobe without a command in progress");

	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(done_q && valid_s1))
		else $error("new command started before the previous result was out");

	a_occ_bound: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q <= OCC_FULL)
		else $error("queue fill count beyond depth");

	a_empty_consistent: assert property (@(posedge clk) disable iff (!arst_n)
		(occ_q == '0) |-> (head_q == tail_q && total_q == '0))
		else $error("empty queue with mismatched pointers or nonzero total");

endmodule

`default_nettype wire

### tb/sv/capture_request_queue_test.sv
// Self-checking testbench for the capture request queue burst scheduler.
// Drives commands through the start/busy handshake and checks every done strobe
// against a cycle-free scheduler model; depends on crq_pkg and the block alone.
`default_nettype none

module capture_request_queue_test;
	import crq_pkg::*;

	localparam int QDEPTH      = 16;
	localparam int CYCLE_LIMIT = 200000;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  len;
		logic        rep;
		logic [31:0] req;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  st;
		logic [31:0] id;
		logic [63:0] frame;
	} outcome_t;

	typedef struct packed {
		cmd_t     cmd;
		logic     typed;
		outcome_t want;
	} plan_row_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic        [1:0]  func;
	logic        [7:0]  burst_length;
	logic               is_repeating;
	logic        [31:0] request_id;
	logic               done;
	logic        [2:0]  status;
	logic        [31:0] result_id;
	logic signed [63:0] frame_number;

	// Scheduler model state.
	logic [31:0] sch_ids [QDEPTH];
	logic [7:0]  sch_lens [QDEPTH];
	int          sch_head;
	int          sch_tail;
	int          sch_occ;
	logic [31:0] sch_total;
	logic [63:0] sch_frame;
	logic        sch_rep_valid;
	logic [31:0] sch_rep_id;
	logic [7:0]  sch_rep_len;
	logic [63:0] sch_rep_end;
	logic [31:0] sch_next_id;

	outcome_t pending_outcomes [$];
	plan_row_t plan [$];
	int errors;
	int results_seen;
	int items_sent;
	int idle_pct;
	int cycles;

	capture_request_queue #(
		.QUEUE_DEPTH(QDEPTH)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(func),
		.burst_length(burst_length),
		.is_repeating(is_repeating),
		.request_id(request_id),
		.done(done),
		.status(status),
		.result_id(result_id),
		.frame_number(frame_number)
	);

	// Clock generation.
	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Run-time guard.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input logic [63:0] got,
			input logic [63:0] want);
		$display("MISMATCH result %0d %s: got %0h, expected %0h", results_seen, what, got,
			want);
		errors++;
	endtask

	// Last frame held by the standing repeating burst, or minus one if never issued.
	function automatic logic [63:0] last_repeat_frame();
		return (sch_rep_end == FRAME_INVALID) ? FRAME_INVALID : sch_rep_end - 64'd1;
	endfunction

	// Works out the result of one command and advances the scheduler state.
	function automatic outcome_t schedule_step(input cmd_t c);
		outcome_t r;
		logic [7:0] l;
		r.st = ST_OK;
		r.id = '0;
		r.frame = FRAME_INVALID;
		case (c.op)
			FUNC_SUBMIT: begin
				if (c.rep) begin
					r.id = sch_next_id;
					sch_next_id = sch_next_id + 32'd1;
					if (sch_rep_valid)
						r.frame = last_repeat_frame();
					sch_rep_valid = 1'b1;
					sch_rep_id = r.id;
					sch_rep_len = c.len;
					sch_rep_end = FRAME_INVALID;
				end else if (sch_occ >= QDEPTH) begin
					r.st = ST_QUEUE_FULL;
				end else begin
					r.id = sch_next_id;
					sch_next_id = sch_next_id + 32'd1;
					sch_ids[sch_tail] = r.id;
					sch_lens[sch_tail] = c.len;
					sch_tail = (sch_tail == QDEPTH - 1) ? 0 : sch_tail + 1;
					sch_occ++;
					sch_total = sch_total + 32'(c.len);
					r.frame = sch_frame + 64'(sch_total) - 64'd1;
				end
			end
			FUNC_GET_NEXT: begin
				if (sch_occ > 0) begin
					l = sch_lens[sch_head];
					r.id = sch_ids[sch_head];
					sch_head = (sch_head == QDEPTH - 1) ? 0 : sch_head + 1;
					sch_occ--;
					sch_total = sch_total - 32'(l);
					r.frame = sch_frame;
					sch_frame = sch_frame + 64'(l);
				end else if (sch_rep_valid) begin
					r.id = sch_rep_id;
					r.frame = sch_frame;
					sch_rep_end = sch_frame + 64'(sch_rep_len);
					sch_frame = sch_frame + 64'(sch_rep_len);
				end else begin
					r.st = ST_NOTHING;
				end
			end
			default: begin
				if (!sch_rep_valid) begin
					r.st = ST_NO_REPEAT;
				end else if (c.op == FUNC_STOP_BY_ID && sch_rep_id != c.req) begin
					r.st = ST_ID_MISMATCH;
				end else begin
					r.frame = last_repeat_frame();
					sch_rep_valid = 1'b0;
					sch_rep_end = FRAME_INVALID;
				end
			end
		endcase
		return r;
	endfunction

	// Builds a command with random content; stops by id usually name the standing burst.
	function automatic cmd_t make_cmd(input logic [1:0] op, input logic rep);
		cmd_t c;
		int pick;
		pick = $urandom_range(9);
		c.op = op;
		c.rep = rep;
		c.len = (pick == 0) ? 8'd0 : (pick == 1) ? 8'hFF : 8'($urandom);
		c.req = $urandom;
		if (op == FUNC_STOP_BY_ID && sch_rep_valid && $urandom_range(2) != 0)
			c.req = sch_rep_id;
		return c;
	endfunction

	function automatic plan_row_t plan_row(input logic [1:0] op, input logic [7:0] len,
			input logic rep, input logic [31:0] req, input logic typed, input logic [2:0] st,
			input logic [31:0] id, input logic [63:0] frame);
		plan_row_t p;
		p.cmd = '{op: op, len: len, rep: rep, req: req};
		p.typed = typed;
		p.want = '{st: st, id: id, frame: frame};
		return p;
	endfunction

	// Presents one command, holds it until the transfer and records its expected result.
	task automatic send_cmd(input cmd_t c, input logic typed, input outcome_t want);
		outcome_t predicted;
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
		func <= c.op;
		burst_length <= c.len;
		is_repeating <= c.rep;
		request_id <= c.req;
		start <= 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		predicted = schedule_step(c);
		pending_outcomes.push_back(typed ? want : predicted);
		items_sent++;
		@(negedge clk);
	endtask

	// Holds the sender off until every outstanding result has arrived.
	task automatic wait_drained();
		start <= 1'b0;
		@(negedge clk);
		while (pending_outcomes.size() != 0)
			@(negedge clk);
	endtask

	// Result checker: each strobe is compared with the oldest expectation.
	always @(posedge clk) begin
		outcome_t w;
		if (arst_n && done) begin
			if (pending_outcomes.size() == 0) begin
				report_mismatch("unexpected result, status", 64'(status), '0);
			end else begin
				w = pending_outcomes.pop_front();
				if (status !== w.st)
					report_mismatch("status", 64'(status), 64'(w.st));
				if (result_id !== w.id)
					report_mismatch("result_id", 64'(result_id), 64'(w.id));
				if (frame_number !== w.frame)
					report_mismatch("frame_number", frame_number, w.frame);
			end
			results_seen++;
		end
	end

	// Stimulus.
	initial begin
		int kind;
		int n;
		cmd_t c;
		errors = 0;
		results_seen = 0;
		items_sent = 0;
		idle_pct = 0;
		cycles = 0;
		sch_head = 0;
		sch_tail = 0;
		sch_occ = 0;
		sch_total = '0;
		sch_frame = '0;
		sch_rep_valid = 1'b0;
		sch_rep_id = '0;
		sch_rep_len = '0;
		sch_rep_end = FRAME_INVALID;
		sch_next_id = '0;
		arst_n <= 1'b0;
		start <= 1'b0;
		func <= FUNC_SUBMIT;
		burst_length <= '0;
		is_repeating <= 1'b0;
		request_id <= '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: empty block, extreme lengths, replacement, mismatch, issue order.
		plan.push_back(plan_row(FUNC_GET_NEXT, 8'd0, 1'b0, 32'd0, 1'b1,
			ST_NOTHING, 32'd0, FRAME_INVALID));
		plan.push_back(plan_row(FUNC_STOP_ANY, 8'hFF, 1'b1, 32'hFFFF_FFFF, 1'b1,
			ST_NO_REPEAT, 32'd0, FRAME_INVALID));
		plan.push_back(plan_row(FUNC_SUBMIT, 8'hFF, 1'b0, 32'hFFFF_FFFF, 1'b1,
			ST_OK, 32'd0, 64'd254));
		plan.push_back(plan_row(FUNC_SUBMIT, 8'd0, 1'b0, 32'd0, 1'b1,
			ST_OK, 32'd1, 64'd254));
		plan.push_back(plan_row(FUNC_SUBMIT, 8'hFF, 1'b1, 32'd0, 1'b1,
			ST_OK, 32'd2, FRAME_INVALID));
		plan.push_back(plan_row(FUNC_SUBMIT, 8'd1, 1'b1, 32'd0, 1'b1,
			ST_OK, 32'd3, FRAME_INVALID));
		plan.push_back(plan_row(FUNC_STOP_BY_ID, 8'd0, 1'b0, 32'd2, 1'b1,
			ST_ID_MISMATCH, 32'd0, FRAME_INVALID));
		plan.push_back(plan_row(FUNC_GET_NEXT, 8'd0, 1'b0, 32'd0, 1'b1,
			ST_OK, 32'd0, 64'd0));
		plan.push_back(plan_row(FUNC_GET_NEXT, 8'd0, 1'b1, 32'd0, 1'b1,
			ST_OK, 32'd1, 64'd255));
		plan.push_back(plan_row(FUNC_GET_NEXT, 8'd0, 1'b0, 32'd0, 1'b1,
			ST_OK, 32'd3, 64'd255));
		plan.push_back(plan_row(FUNC_STOP_BY_ID, 8'd0, 1'b0, 32'd3, 1'b1,
			ST_OK, 32'd0, 64'd255));
		foreach (plan[i])
			send_cmd(plan[i].cmd, plan[i].typed, plan[i].want);

		// Fill the queue, then one more one-shot submit must be refused.
		repeat (QDEPTH)
			send_cmd(make_cmd(FUNC_SUBMIT, 1'b0), 1'b0, '0);
		c = '{op: FUNC_SUBMIT, len: 8'd9, rep: 1'b0, req: 32'd0};
		send_cmd(c, 1'b1, '{st: ST_QUEUE_FULL, id: 32'd0, frame: FRAME_INVALID});
		wait_drained();

		// Random phases with different sender idling, drained in between.
		for (int ph = 0; ph < 4; ph++) begin
			idle_pct = (ph == 1) ? 54 : (ph == 3) ? 33 : 0;
			n = items_sent + 100;
			while (items_sent < n) begin
				kind = $urandom_range(99);
				if (kind < 20) begin
					// Run of one-shot submits, often to a full queue, then partly drain.
					repeat ($urandom_range(4, QDEPTH + 2))
						send_cmd(make_cmd(FUNC_SUBMIT, 1'b0), 1'b0, '0);
					repeat ($urandom_range(1, QDEPTH))
						send_cmd(make_cmd(FUNC_GET_NEXT, 1'($urandom)), 1'b0, '0);
				end else if (kind < 35) begin
					// Repeating burst lifecycle: submit, up to three get-next commands, then a stop.
					send_cmd(make_cmd(FUNC_SUBMIT, 1'b1), 1'b0, '0);
					repeat ($urandom_range(0, 3))
						send_cmd(make_cmd(FUNC_GET_NEXT, 1'($urandom)), 1'b0, '0);
					send_cmd(make_cmd(2'($urandom_range(2, 3)), 1'($urandom)), 1'b0, '0);
				end else if (kind < 60) begin
					send_cmd(make_cmd(FUNC_SUBMIT, 1'($urandom_range(3) == 0)), 1'b0, '0);
				end else if (kind < 85) begin
					send_cmd(make_cmd(FUNC_GET_NEXT, 1'($urandom)), 1'b0, '0);
				end else begin
					send_cmd(make_cmd(2'($urandom_range(2, 3)), 1'($urandom)), 1'b0, '0);
				end
			end
			wait_drained();
		end

		// Let any stray strobe show before the verdict.
		repeat (8) @(negedge clk);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

`default_nettype wire
